@@ design/gpt_pkg.sv @@
// Shared types, codes and helpers for the grid path token parser.
// No dependencies; gpt_queue, gpt_front, gpt_back and the top level import this package.
package gpt_pkg;

  // Characters with meaning to the parser
  localparam logic [7:0] CH_DASH   = 8'h2D;  // '-'
  localparam logic [7:0] CH_COMMA  = 8'h2C;  // ','
  localparam logic [7:0] CH_RBRACK = 8'h5D;  // ']'
  localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE   = 8'h39;  // '9'

  // Coordinate accumulators saturate here (one past the largest legal value)
  localparam logic [8:0] COORD_SAT = 9'd256;

  // Cell numbering wraps at this count
  localparam int unsigned MAX_CELLS = 65536;
  localparam logic [15:0] CELL_LAST = 16'(MAX_CELLS - 1);

  // Error codes of a result
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_SYNTAX = 2'd1;  // cell ended before its ']'
  localparam logic [1:0] ERR_RANGE  = 2'd2;  // coordinate out of the grid

  // Line tags kept in the visited memory; tag zero means never visited
  localparam int unsigned EPOCH_W     = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_CLEAR = '0;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_MAX   = '1;

  // Decoupling queue between front and back end
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Parse phase of the current cell
  typedef enum logic [2:0] {
    PH_LETTER,
    PH_SKIP,
    PH_ROW,
    PH_ROW_WAIT,
    PH_COL,
    PH_COL_WAIT,
    PH_TAIL
  } phase_t;

  // One finished cell, as handed from the front end to the back end
  typedef struct packed {
    logic [7:0]  letter;
    logic [7:0]  row;
    logic [7:0]  column;
    logic [15:0] cell_number;
    logic [1:0]  error;
    logic        last;
    logic        lookup;   // clean cell: check and mark the visited map
  } cell_t;

  // acc * 10 + digit, saturated at COORD_SAT
  function automatic logic [8:0] accum_digit(input logic [8:0] acc, input logic [3:0] dig);
    logic [12:0] v;
    v = 13'(acc) * 13'd10 + 13'(dig);
    return (v > 13'(COORD_SAT)) ? COORD_SAT : v[8:0];
  endfunction

endpackage

@@ design/gpt_if.sv @@
// Valid/ready channel interfaces of the grid path token parser.
// Depends on nothing; used by the front end, back end and top level.
interface gpt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_line;

  modport source (output valid, output ch, output end_of_line, input ready);
  modport sink   (input valid, input ch, input end_of_line, output ready);
endinterface

interface gpt_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  letter;
  logic [7:0]  row;
  logic [7:0]  column;
  logic [15:0] cell_number;
  logic        revisit;
  logic        cycle_flag;
  logic [1:0]  error;
  logic        last;

  modport source (output valid, output letter, output row, output column,
                  output cell_number, output revisit, output cycle_flag,
                  output error, output last, input ready);
  modport sink   (input valid, input letter, input row, input column,
                  input cell_number, input revisit, input cycle_flag,
                  input error, input last, output ready);
endinterface

@@ design/gpt_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module gpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read returns the old contents when both ports hit one address
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/gpt_queue.sv @@
// Short request queue between the parser front end and the map back end.
// Depends on gpt_pkg for its depth.
module gpt_queue
  import gpt_pkg::*;
#(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             pop_valid
);

  logic [WIDTH-1:0]  entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign push_ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // Pointers wrap naturally: the depth is a power of two
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ design/gpt_front.sv @@
// Parser front end: takes characters, tracks the parse phase and coordinates,
// and pushes one finished cell per '-' or end of line. Depends on gpt_pkg, gpt_if.
module gpt_front
  import gpt_pkg::*;
#(
  parameter int unsigned GRID_SIZE = 256,
  parameter int unsigned COORD_W   = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  gpt_in_if.sink                 in_chan,
  output logic                   push,
  output cell_t                  push_cell,
  output logic [2*COORD_W-1:0]   push_addr,
  input  logic                   push_ready
);

  phase_t      phase_r, phase_nxt, phase_adv, phase_cur;
  logic [7:0]  letter_r, letter_nxt, letter_cur;
  logic [8:0]  row_r, row_nxt, row_cur;
  logic [8:0]  col_r, col_nxt, col_cur;
  logic [15:0] cnt_r, cnt_nxt;
  logic        accept, is_sep, is_dig, is_end;
  logic [1:0]  err;

  assign in_chan.ready = push_ready;
  assign accept        = in_chan.valid && push_ready;
  assign is_sep        = (in_chan.ch == CH_DASH);
  assign is_dig        = in_chan.ch inside {[CH_ZERO:CH_NINE]};
  assign is_end        = is_sep || in_chan.end_of_line;

  // Phase advance for a non-separator character
  always_comb begin
    case (phase_r)
      PH_LETTER:   phase_adv = PH_SKIP;
      PH_SKIP:     phase_adv = PH_ROW;
      PH_ROW: begin
        if (in_chan.ch == CH_COMMA) phase_adv = PH_COL;
        else if (is_dig)            phase_adv = PH_ROW;
        else                        phase_adv = PH_ROW_WAIT;
      end
      PH_ROW_WAIT: phase_adv = (in_chan.ch == CH_COMMA) ? PH_COL : PH_ROW_WAIT;
      PH_COL: begin
        if (in_chan.ch == CH_RBRACK) phase_adv = PH_TAIL;
        else if (is_dig)             phase_adv = PH_COL;
        else                         phase_adv = PH_COL_WAIT;
      end
      PH_COL_WAIT: phase_adv = (in_chan.ch == CH_RBRACK) ? PH_TAIL : PH_COL_WAIT;
      default:     phase_adv = PH_TAIL;
    endcase
  end

  // Next state: a separator leaves the phase alone, a cell end restarts it
  always_comb begin
    phase_cur = is_sep ? phase_r : phase_adv;
    phase_nxt = phase_r;
    if (accept) begin
      phase_nxt = is_end ? PH_LETTER : phase_cur;
    end
  end

  // Field updates for this character
  always_comb begin
    letter_cur = letter_r;
    row_cur    = row_r;
    col_cur    = col_r;
    if (!is_sep) begin
      if (phase_r == PH_LETTER) letter_cur = in_chan.ch;
      if (phase_r == PH_ROW && is_dig) row_cur = accum_digit(row_r, in_chan.ch[3:0]);
      if (phase_r == PH_COL && is_dig) col_cur = accum_digit(col_r, in_chan.ch[3:0]);
    end
  end

  // Classify the finished cell
  always_comb begin
    if (phase_cur != PH_TAIL) begin
      err = ERR_SYNTAX;
    end else if (row_cur[8] || col_cur[8] || (32'(row_cur) >= GRID_SIZE)
                 || (32'(col_cur) >= GRID_SIZE)) begin
      err = ERR_RANGE;
    end else begin
      err = ERR_NONE;
    end
  end

  always_comb begin
    push                  = accept && is_end;
    push_cell.letter      = letter_cur;
    push_cell.row         = row_cur[8] ? 8'hFF : row_cur[7:0];
    push_cell.column      = col_cur[8] ? 8'hFF : col_cur[7:0];
    push_cell.cell_number = cnt_r;
    push_cell.error       = err;
    push_cell.last        = in_chan.end_of_line;
    push_cell.lookup      = (err == ERR_NONE);
    push_addr             = {COORD_W'(row_cur), COORD_W'(col_cur)};
  end

  // Register updates: fields cleared at each cell end, cell number at end of line or wrap
  always_comb begin
    letter_nxt = letter_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    cnt_nxt    = cnt_r;
    if (accept) begin
      if (is_end) begin
        letter_nxt = '0;
        row_nxt    = '0;
        col_nxt    = '0;
        if (in_chan.end_of_line || cnt_r == CELL_LAST) cnt_nxt = '0;
        else                                           cnt_nxt = cnt_r + 16'd1;
      end else begin
        letter_nxt = letter_cur;
        row_nxt    = row_cur;
        col_nxt    = col_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_LETTER;
      letter_r <= '0;
      row_r    <= '0;
      col_r    <= '0;
      cnt_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      letter_r <= letter_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ design/gpt_back.sv @@
// Map back end: checks and marks cells in the visited memory by line tag,
// tracks the cycle flag and drives the result register. Depends on gpt_pkg,
// gpt_if and gpt_ram.
module gpt_back
  import gpt_pkg::*;
#(
  parameter int unsigned ADDR_W = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  cell_t             q_cell,
  input  logic [ADDR_W-1:0] q_addr,
  output logic              q_pop,
  gpt_out_if.source         out_chan
);

  // Lookup stage
  logic              b_valid_r, b_valid_nxt;
  cell_t             b_cell_r;
  logic [ADDR_W-1:0] b_addr_r;
  logic              b_fwd_r, b_fwd_nxt;
  // Line state and clearing pass
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic               cycle_seen_r, cycle_seen_nxt;
  logic               sweep_r, sweep_nxt;
  logic [ADDR_W-1:0]  sweep_cnt_r, sweep_cnt_nxt;
  // Result register
  logic        out_valid_r, out_valid_nxt;
  cell_t       out_cell_r;
  logic        out_rev_r, out_cyc_r;
  // Memory ports and stage control
  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [EPOCH_W-1:0] ram_wdata, ram_rdata;
  logic               hit, b_adv, wrap_hold;

  gpt_ram #(
    .WIDTH (EPOCH_W),
    .DEPTH (2 ** ADDR_W)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (q_addr),
    .rdata (ram_rdata)
  );

  // Visited when the tag matches this line, or the cell just ahead wrote it
  assign hit   = b_cell_r.lookup && (b_fwd_r || ram_rdata == epoch_r);
  assign b_adv = b_valid_r && (!out_valid_r || out_chan.ready);
  // Hold new requests while the line that exhausts the tags drains
  assign wrap_hold = b_valid_r && b_cell_r.last && (epoch_r == EPOCH_MAX);
  assign q_pop  = q_valid && !sweep_r && !wrap_hold && (!b_valid_r || b_adv);
  assign ram_re = q_pop;

  // Memory write: clearing pass or tag of the current line
  always_comb begin
    if (sweep_r) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_cnt_r;
      ram_wdata = EPOCH_CLEAR;
    end else begin
      ram_we    = b_adv && b_cell_r.lookup;
      ram_waddr = b_addr_r;
      ram_wdata = epoch_r;
    end
  end

  // Stage, line and sweep control
  always_comb begin
    b_valid_nxt    = q_pop || (b_valid_r && !b_adv);
    b_fwd_nxt      = b_fwd_r;
    if (q_pop) begin
      b_fwd_nxt = b_adv && b_cell_r.lookup && !b_cell_r.last && (b_addr_r == q_addr);
    end
    epoch_nxt      = epoch_r;
    cycle_seen_nxt = cycle_seen_r;
    sweep_nxt      = sweep_r;
    sweep_cnt_nxt  = sweep_cnt_r;
    if (sweep_r) begin
      sweep_cnt_nxt = sweep_cnt_r + ADDR_W'(1);
      if (sweep_cnt_r == '1) sweep_nxt = 1'b0;
    end
    if (b_adv) begin
      if (b_cell_r.last) begin
        cycle_seen_nxt = 1'b0;
        if (epoch_r == EPOCH_MAX) begin
          epoch_nxt     = EPOCH_FIRST;
          sweep_nxt     = 1'b1;
          sweep_cnt_nxt = '0;
        end else begin
          epoch_nxt = epoch_r + EPOCH_W'(1);
        end
      end else begin
        cycle_seen_nxt = cycle_seen_r || hit;
      end
    end
    out_valid_nxt = b_adv || (out_valid_r && !out_chan.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r    <= 1'b0;
      b_fwd_r      <= 1'b0;
      epoch_r      <= EPOCH_FIRST;
      cycle_seen_r <= 1'b0;
      sweep_r      <= 1'b1;
      sweep_cnt_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      b_valid_r    <= b_valid_nxt;
      b_fwd_r      <= b_fwd_nxt;
      epoch_r      <= epoch_nxt;
      cycle_seen_r <= cycle_seen_nxt;
      sweep_r      <= sweep_nxt;
      sweep_cnt_r  <= sweep_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      b_cell_r <= q_cell;
      b_addr_r <= q_addr;
    end
    if (b_adv) begin
      out_cell_r <= b_cell_r;
      out_rev_r  <= hit;
      out_cyc_r  <= cycle_seen_r || hit;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.letter      = out_cell_r.letter;
  assign out_chan.row         = out_cell_r.row;
  assign out_chan.column      = out_cell_r.column;
  assign out_chan.cell_number = out_cell_r.cell_number;
  assign out_chan.revisit     = out_rev_r;
  assign out_chan.cycle_flag  = out_cyc_r;
  assign out_chan.error       = out_cell_r.error;
  assign out_chan.last        = out_cell_r.last;

endmodule

@@ design/grid_path_token_parser_top.sv @@
// Grid path token parser: one character per request on in_chan (ch, end_of_line),
// one result per cell on out_chan. Cells are written letter[row,col] joined by '-'.
//
// A cell ends at each '-' and at the character flagged end_of_line; the result
// carries letter, row, column, cell_number, revisit, cycle_flag, error and last.
// Throughput: one character per cycle while the queue has room. A result passes
// through the queue, the lookup stage and the result register to out_chan.
// Visited cells live in a memory of line tags, one read and
// one write per cycle, so no per-line clear is needed. After reset, and after
// every 255th line, a clearing pass writes all 2**(2*clog2(GRID_SIZE)) entries
// (65536 at the default size). During the pass the front end still takes
// characters until the two-entry queue fills, then holds in_chan.ready low.
// When out_chan.ready is low the result register holds, the lookup stage and
// queue fill behind it, and in_chan.ready drops once the queue is full.
// Reset (rst_n low, synchronous) returns the parser to the start of a line.
// Depends on gpt_pkg, gpt_if, gpt_ram, gpt_queue, gpt_front and gpt_back.
module grid_path_token_parser_top
  import gpt_pkg::*;
#(
  parameter int unsigned GRID_SIZE = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  gpt_in_if.sink     in_chan,
  gpt_out_if.source  out_chan
);

  localparam int unsigned COORD_W = $clog2(GRID_SIZE);
  localparam int unsigned ADDR_W  = 2 * COORD_W;
  localparam int unsigned QW      = $bits(cell_t) + ADDR_W;

  logic              f_push, f_push_ready;
  cell_t             f_cell;
  logic [ADDR_W-1:0] f_addr;
  logic [QW-1:0]     q_data;
  logic              q_valid, q_pop;
  cell_t             q_cell;
  logic [ADDR_W-1:0] q_addr;

  gpt_front #(
    .GRID_SIZE (GRID_SIZE),
    .COORD_W   (COORD_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .push       (f_push),
    .push_cell  (f_cell),
    .push_addr  (f_addr),
    .push_ready (f_push_ready)
  );

  gpt_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (f_push),
    .push_data  ({f_cell, f_addr}),
    .push_ready (f_push_ready),
    .pop        (q_pop),
    .pop_data   (q_data),
    .pop_valid  (q_valid)
  );

  assign q_cell = q_data[QW-1:ADDR_W];
  assign q_addr = q_data[ADDR_W-1:0];

  gpt_back #(
    .ADDR_W (ADDR_W)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_cell   (q_cell),
    .q_addr   (q_addr),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule
